// File: design/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: design/ipid_pkg.sv
// Types, constants and level tables for the incremental PID current loop.
`timescale 1ns / 1ps
`default_nettype none

package ipid_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_RESET = 2'd2,
    OP_TICK  = 2'd3
  } opcode_t;

  localparam logic [1:0] CFG_PROP  = 2'd0;
  localparam logic [1:0] CFG_INTEG = 2'd1;
  localparam logic [1:0] CFG_DERIV = 2'd2;

  localparam logic [15:0] KP_RESET = 16'd0;
  localparam logic [15:0] KI_RESET = 16'd41;
  localparam logic [15:0] KD_RESET = 16'd0;

  localparam logic signed [12:0] ERR_LIMIT = 13'sd100;
  localparam logic [11:0] DRIVE_MAX = 12'd4000;

  typedef struct packed {
    opcode_t     opcode;
    logic [1:0]  level_select;
    logic [11:0] measured_current;
  } cmd_t;

  typedef struct packed {
    logic [11:0] drive_value;
    logic        loop_enabled;
  } rsp_t;

  typedef struct packed {
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
  } gains_t;

  function automatic logic [11:0] level_setpoint(input logic [1:0] level);
    logic [11:0] v;
    case (level)
      2'd0:    v = 12'd0;
      2'd1:    v = 12'd500;
      2'd2:    v = 12'd1000;
      2'd3:    v = 12'd3000;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

  function automatic logic [11:0] level_drive(input logic [1:0] level);
    logic [11:0] v;
    case (level)
      2'd0:    v = 12'd4000;
      2'd1:    v = 12'd3500;
      2'd2:    v = 12'd3250;
      2'd3:    v = 12'd500;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: design/ipid_cfg.sv
// Gain register file written through the configuration port.
`timescale 1ns / 1ps
`default_nettype none

module ipid_cfg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wen,
  input  wire logic [1:0]         cfg_addr,
  input  wire logic [15:0]        cfg_data,
  output ipid_pkg::gains_t        gains
);

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.kp <= ipid_pkg::KP_RESET;
      gains.ki <= ipid_pkg::KI_RESET;
      gains.kd <= ipid_pkg::KD_RESET;
    end else if (cfg_wen) begin
      case (cfg_addr)
        ipid_pkg::CFG_PROP:  gains.kp <= cfg_data;
        ipid_pkg::CFG_INTEG: gains.ki <= cfg_data;
        ipid_pkg::CFG_DERIV: gains.kd <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/ipid_in_stage.sv
// Input register holding one command word ahead of the update logic.
`timescale 1ns / 1ps
`default_nettype none

module ipid_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire ipid_pkg::cmd_t cmd,
  input  wire logic          advance,
  output logic               s1_valid,
  output ipid_pkg::cmd_t     s1_word
);

  logic load;

  assign cmd_stall = s1_valid && !advance;
  assign load      = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_word <= cmd;
    end
  end

endmodule

`default_nettype wire

// File: design/ipid_core.sv
// Loop state and combinational velocity-form PID update.
`timescale 1ns / 1ps
`default_nettype none

module ipid_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire ipid_pkg::cmd_t   s1_word,
  input  wire ipid_pkg::gains_t gains,
  output ipid_pkg::rsp_t        result
);

  logic [11:0]        drive_acc, drive_acc_next;
  logic signed [7:0]  err_prev, err_prev_next;
  logic signed [7:0]  err_prev2, err_prev2_next;
  logic [11:0]        target_current, target_current_next;
  logic               run_flag, run_flag_next;

  logic signed [12:0] diff;
  logic signed [7:0]  e0;
  logic signed [8:0]  d1;
  logic signed [8:0]  d_prev;
  logic signed [9:0]  d2;
  logic signed [25:0] p_prop;
  logic signed [24:0] p_integ;
  logic signed [26:0] p_deriv;
  logic signed [27:0] sum;
  logic signed [27:0] sum_adj;
  logic signed [19:0] inc;
  logic signed [20:0] drive_sum;
  logic [11:0]        drive_tick;

  // error, clamped to +/-100
  always_comb begin
    diff = $signed({1'b0, s1_word.measured_current}) - $signed({1'b0, target_current});
    if (diff > ipid_pkg::ERR_LIMIT) begin
      e0 = 8'(ipid_pkg::ERR_LIMIT);
    end else if (diff < -ipid_pkg::ERR_LIMIT) begin
      e0 = 8'(-ipid_pkg::ERR_LIMIT);
    end else begin
      e0 = diff[7:0];
    end
  end

  assign d1      = 9'(e0) - 9'(err_prev);
  assign d_prev  = 9'(err_prev) - 9'(err_prev2);
  assign d2      = 10'(d1) - 10'(d_prev);
  assign p_prop  = $signed({1'b0, gains.kp}) * d1;
  assign p_integ = $signed({1'b0, gains.ki}) * e0;
  assign p_deriv = $signed({1'b0, gains.kd}) * d2;
  assign sum     = 28'(p_prop) + 28'(p_integ) + 28'(p_deriv);

  // divide by 256, rounding toward zero
  assign sum_adj   = sum + (sum[27] ? 28'sd255 : 28'sd0);
  assign inc       = sum_adj[27:8];
  assign drive_sum = $signed({9'b0, drive_acc}) + 21'(inc);

  always_comb begin
    if (drive_sum < 21'sd0) begin
      drive_tick = 12'd0;
    end else if (drive_sum > $signed({9'b0, ipid_pkg::DRIVE_MAX})) begin
      drive_tick = ipid_pkg::DRIVE_MAX;
    end else begin
      drive_tick = drive_sum[11:0];
    end
  end

  always_comb begin
    drive_acc_next      = drive_acc;
    err_prev_next       = err_prev;
    err_prev2_next      = err_prev2;
    target_current_next = target_current;
    run_flag_next       = run_flag;
    case (s1_word.opcode)
      ipid_pkg::OP_START: begin
        target_current_next = ipid_pkg::level_setpoint(s1_word.level_select);
        drive_acc_next      = ipid_pkg::level_drive(s1_word.level_select);
        err_prev_next       = 8'sd0;
        err_prev2_next      = 8'sd0;
        run_flag_next       = 1'b1;
      end
      ipid_pkg::OP_STOP: begin
        err_prev_next  = 8'sd0;
        err_prev2_next = 8'sd0;
        run_flag_next  = 1'b0;
      end
      ipid_pkg::OP_RESET: begin
        drive_acc_next = 12'd0;
        err_prev_next  = 8'sd0;
        err_prev2_next = 8'sd0;
        run_flag_next  = 1'b0;
      end
      ipid_pkg::OP_TICK: begin
        if (run_flag) begin
          drive_acc_next = drive_tick;
          err_prev_next  = e0;
          err_prev2_next = err_prev;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_acc      <= 12'd0;
      err_prev       <= 8'sd0;
      err_prev2      <= 8'sd0;
      target_current <= 12'd0;
      run_flag       <= 1'b0;
    end else if (advance) begin
      drive_acc      <= drive_acc_next;
      err_prev       <= err_prev_next;
      err_prev2      <= err_prev2_next;
      target_current <= target_current_next;
      run_flag       <= run_flag_next;
    end
  end

  assign result.drive_value  = drive_acc_next;
  assign result.loop_enabled = run_flag_next;

endmodule

`default_nettype wire

// File: design/ipid_out_stage.sv
// Result register and output handshake.
`timescale 1ns / 1ps
`default_nettype none

module ipid_out_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s1_valid,
  output logic               advance,
  input  wire ipid_pkg::rsp_t result,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output ipid_pkg::rsp_t     rsp
);

  assign advance = s1_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

endmodule

`default_nettype wire

// File: design/incremental_pid_current_loop_unit.sv
// Top level of the incremental PID current loop.
//
//   channel | direction | handshake            | word
//   cmd     | in        | cmd_valid/cmd_stall  | opcode, level_select, measured_current
//   rsp     | out       | rsp_valid/rsp_stall  | drive_value, loop_enabled
//   cfg     | in        | cfg_wen              | cfg_addr, cfg_data (gains)
//
// One word per cycle sustained while rsp is not stalled; the whole update (error clamp, three gain
// products, sum, saturate) runs in the cycle between input and result register.
// A cmd word waits in the input register until the result register takes its result.
// Reset loads the gains with their defaults and clears drive, target, history and enable.
// A stalled rsp holds the result; cmd stalls only while both registers are full.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module incremental_pid_current_loop_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire ipid_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output ipid_pkg::rsp_t     rsp,
  input  wire logic          cfg_wen,
  input  wire logic [1:0]    cfg_addr,
  input  wire logic [15:0]   cfg_data
);

  ipid_pkg::gains_t gains;
  ipid_pkg::cmd_t   s1_word;
  ipid_pkg::rsp_t   result;
  logic             s1_valid;
  logic             advance;

  ipid_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .gains    (gains)
  );

  ipid_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_word   (s1_word)
  );

  ipid_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .s1_word (s1_word),
    .gains   (gains),
    .result  (result)
  );

  ipid_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .advance   (advance),
    .result    (result),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  `ASSERT_NOW(a_drive_range, clk, rst, rsp_valid, rsp.drive_value <= ipid_pkg::DRIVE_MAX)
  `ASSERT_NOW(a_stall_cause, clk, rst, cmd_stall, rsp_valid && rsp_stall && s1_valid)
  `ASSERT_ALWAYS(a_reset_empty, clk, $past(rst), !rsp_valid && !s1_valid)

endmodule

`default_nettype wire
